/* sv/implicit_tree_availability_bitmap_top_macros.svh */
// Assertion macros for the implicit tree availability bitmap block.
// Included by the top level; the macros use its clock and reset ports.
`ifndef IMPLICIT_TREE_AVAILABILITY_BITMAP_TOP_MACROS_SVH
`define IMPLICIT_TREE_AVAILABILITY_BITMAP_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ITAB_ASSERT_IMP(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define ITAB_ASSERT_NXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

/* sv/itab_pkg.sv */
// Shared constants, codes and helper functions for the availability bitmap block.
// No dependencies; used by implicit_tree_availability_bitmap_top.
package itab_pkg;

   // Default sizing of the subtree and of the content map set.
   localparam int MAX_LEVELS_DEF     = 5;
   localparam int CONTENT_LAYERS_DEF = 4;

   // Field widths.
   localparam int MORTON_W   = 48;
   localparam int LEVEL_W    = 4;
   localparam int TARGET_W   = 2;
   localparam int LAYER_W    = 2;
   localparam int TREE_W     = 48;
   localparam int IDX_W      = MORTON_W + 1;
   localparam int BYTE_W     = IDX_W - 3;
   localparam int REQ_DATA_W = 56;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 3;

   // Operation codes.
   localparam logic OP_QUERY = 1'b0;
   localparam logic OP_SET   = 1'b1;

   // Target map codes.
   localparam logic [TARGET_W-1:0] TGT_TILE    = 2'd0;
   localparam logic [TARGET_W-1:0] TGT_CONTENT = 2'd1;
   localparam logic [TARGET_W-1:0] TGT_CHILD   = 2'd2;
   localparam logic [TARGET_W-1:0] TGT_BAD     = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_OCTREE_MODE   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LEVELS        = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CONTENT_COUNT = 2'd2;

   // Fill bytes used when a constant map becomes a bitstream.
   localparam logic [7:0] FILL_ONES  = 8'hFF;
   localparam logic [7:0] FILL_ZEROS = 8'h00;

   // Number of tiles in all levels above lvl: the sum of 4^i or 8^i for i < lvl.
   // The terms never overlap, so the sum is an OR of shifted ones.
   function automatic logic [TREE_W-1:0] tree_tiles(input logic octree,
                                                   input logic [LEVEL_W-1:0] lvl);
      logic [TREE_W-1:0] acc;
      int i;
      acc = '0;
      for (i = 0; i < (2 ** LEVEL_W); i++) begin
         if (LEVEL_W'(i) < lvl) begin
            acc = acc | (TREE_W'(1) << (octree ? (3 * i) : (2 * i)));
         end
      end
      return acc;
   endfunction

endpackage

/* sv/implicit_tree_availability_bitmap_top.sv */
// Availability map store for one implicit subtree; uses itab_pkg and the assertion macros.
// Each accepted request is decoded in ST_EVAL; a query on a constant map, a set that leaves
// it unchanged, or a refusal at decode loads the response there. A bitstream access reads one
// map byte in ST_ACCESS (which answers a refusal at the byte bound); ST_MODIFY writes it back
// on a set and loads the response. A set that changes a constant map first runs ST_FILL.
// Reset is synchronous: every map is constant (tile 1, others 0); bytes fill on conversion.
`include "implicit_tree_availability_bitmap_top_macros.svh"

module implicit_tree_availability_bitmap_top #(
   parameter int MAX_LEVELS     = itab_pkg::MAX_LEVELS_DEF,
   parameter int CONTENT_LAYERS = itab_pkg::CONTENT_LAYERS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: content_layer[1:0], level[5:2], morton_index[53:6], set_value[54]
   input  logic [itab_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: op[0], target[2:1]
   input  logic [itab_pkg::REQ_USER_W-1:0]     req_tuser,
   // Response channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: available[0], rejected[1]
   output logic [itab_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // Configuration write port.
   input  logic                                csr_we,
   input  logic [itab_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [itab_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // Map geometry derived from the subtree size.
   localparam int TreeTiles  = ((1 << (3 * MAX_LEVELS)) - 1) / 7;
   localparam int TreeBytes  = (TreeTiles + 7) / 8;
   localparam int ChildBytes = ((1 << (3 * MAX_LEVELS)) + 7) / 8;
   localparam int NMaps      = CONTENT_LAYERS + 2;
   localparam int MemDepth   = TreeBytes * (NMaps - 1) + ChildBytes;
   localparam int AW         = $clog2(MemDepth);
   localparam int LW         = $clog2(ChildBytes + 1);
   localparam int MapW       = $clog2(NMaps);
   localparam int CntW       = $clog2(CONTENT_LAYERS + 1) + 3;
   localparam int LvlW       = itab_pkg::LEVEL_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_FILL,
      ST_ACCESS,
      ST_MODIFY
   } state_type;

   // Control registers.
   state_type                       state_ff, state_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            octree_ff, octree_in;
   logic [2:0]                      levels_ff, levels_in;
   logic [2:0]                      count_ff, count_in;
   logic                            map_const_ff [NMaps];
   logic                            map_const_in [NMaps];
   logic                            map_val_ff [NMaps];
   logic [LW-1:0]                   map_len_ff [NMaps];
   logic [LW-1:0]                   map_len_in [NMaps];

   // Payload registers.
   logic                            op_ff, op_in;
   logic [itab_pkg::TARGET_W-1:0]   target_ff, target_in;
   logic [itab_pkg::LAYER_W-1:0]    layer_ff, layer_in;
   logic [LvlW-1:0]                 level_ff, level_in;
   logic [itab_pkg::MORTON_W-1:0]   morton_ff, morton_in;
   logic                            sv_ff, sv_in;
   logic [MapW-1:0]                 m_ff, m_in;
   logic [AW-1:0]                   mbase_ff, mbase_in;
   logic [itab_pkg::BYTE_W-1:0]     byte_ff, byte_in;
   logic [2:0]                      pos_ff, pos_in;
   logic                            oor_ff, oor_in;
   logic [LW-1:0]                   fill_len_ff, fill_len_in;
   logic [LW-1:0]                   fill_cnt_ff, fill_cnt_in;
   logic                            fill_val_ff, fill_val_in;
   logic                            rsp_avail_ff, rsp_avail_in;
   logic                            rsp_rej_ff, rsp_rej_in;

   // Map memory: tile map, content maps, then the child-subtree map.
   logic [7:0]                      mem [MemDepth];
   logic [7:0]                      rd_data_ff;
   logic                            mem_we, mem_re;
   logic [AW-1:0]                   mem_wa, mem_ra;
   logic [7:0]                      mem_wd;

   // Decode helpers.
   logic                            out_free, rsp_load, req_fire;
   logic [CntW-1:0]                 cnt_eff;
   logic [LvlW-1:0]                 lsub;
   logic                            bad_req, is_child;
   logic [MapW-1:0]                 m_sel;
   logic [5:0]                      lvl_sh, sub_sh;
   logic [itab_pkg::TREE_W-1:0]     base_tiles;
   logic [itab_pkg::IDX_W-1:0]      bit_idx;
   logic [63:0]                     fill_tiles;
   logic                            acc_rej;
   logic [7:0]                      mod_byte;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_rej_ff, rsp_avail_ff};

   // Effective configuration: clamp the level and layer counts.
   assign cnt_eff = (CntW'(count_ff) > CntW'(CONTENT_LAYERS)) ?
                    CntW'(CONTENT_LAYERS) : CntW'(count_ff);
   assign lsub    = (LvlW'(levels_ff) > LvlW'(MAX_LEVELS)) ?
                    LvlW'(MAX_LEVELS) : LvlW'(levels_ff);

   // Request decode on the registered word.
   assign is_child = (target_ff == itab_pkg::TGT_CHILD);
   assign bad_req  = (target_ff == itab_pkg::TGT_BAD) ||
                     ((target_ff == itab_pkg::TGT_CONTENT) &&
                      (CntW'(layer_ff) >= cnt_eff));

   always_comb begin
      m_sel = '0;
      if (!bad_req) begin
         if (target_ff == itab_pkg::TGT_CONTENT) begin
            m_sel = MapW'(layer_ff) + MapW'(1);
         end else if (is_child) begin
            m_sel = MapW'(NMaps - 1);
         end
      end
   end

   // Level offset, bit index and the byte length of a converted map.
   assign lvl_sh     = octree_ff ? (6'(level_ff) * 6'd3) : (6'(level_ff) * 6'd2);
   assign sub_sh     = octree_ff ? (6'(lsub) * 6'd3) : (6'(lsub) * 6'd2);
   assign base_tiles = is_child ? '0 : itab_pkg::tree_tiles(octree_ff, level_ff);
   assign bit_idx    = itab_pkg::IDX_W'(morton_ff) + itab_pkg::IDX_W'(base_tiles);
   assign fill_tiles = is_child ? (64'd1 << sub_sh) :
                       64'(itab_pkg::tree_tiles(octree_ff, lsub));

   // Bitstream access is refused outside the level or beyond the stored bytes.
   assign acc_rej = oor_ff || (byte_ff >= itab_pkg::BYTE_W'(map_len_ff[m_ff]));

   always_comb begin
      mod_byte         = rd_data_ff;
      mod_byte[pos_ff] = sv_ff;
   end

   // Memory port control.
   always_comb begin
      mem_we = 1'b0;
      mem_wa = mbase_ff + AW'(byte_ff);
      mem_wd = mod_byte;
      mem_re = 1'b0;
      mem_ra = mbase_ff + AW'(byte_ff);
      unique case (state_ff)
         ST_FILL: begin
            mem_wa = mbase_ff + AW'(fill_cnt_ff);
            mem_wd = fill_val_ff ? itab_pkg::FILL_ONES : itab_pkg::FILL_ZEROS;
            mem_we = (fill_cnt_ff != fill_len_ff);
         end
         ST_ACCESS: begin
            mem_re = !acc_rej;
         end
         ST_MODIFY: begin
            mem_we = out_free && (op_ff == itab_pkg::OP_SET);
         end
         default: begin
         end
      endcase
   end

   // Next-state and next-value logic of the sequencer.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      octree_in    = octree_ff;
      levels_in    = levels_ff;
      count_in     = count_ff;
      map_const_in = map_const_ff;
      map_len_in   = map_len_ff;
      op_in        = op_ff;
      target_in    = target_ff;
      layer_in     = layer_ff;
      level_in     = level_ff;
      morton_in    = morton_ff;
      sv_in        = sv_ff;
      m_in         = m_ff;
      mbase_in     = mbase_ff;
      byte_in      = byte_ff;
      pos_in       = pos_ff;
      oor_in       = oor_ff;
      fill_len_in  = fill_len_ff;
      fill_cnt_in  = fill_cnt_ff;
      fill_val_in  = fill_val_ff;
      rsp_avail_in = rsp_avail_ff;
      rsp_rej_in   = rsp_rej_ff;
      rsp_load     = 1'b0;

      // The response register drains independently of the sequencer.
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // Configuration writes.
      if (csr_we) begin
         unique case (csr_addr)
            itab_pkg::CSR_OCTREE_MODE:   octree_in = csr_wdata[0];
            itab_pkg::CSR_LEVELS:        levels_in = csr_wdata;
            itab_pkg::CSR_CONTENT_COUNT: count_in  = csr_wdata;
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in     = req_tuser[0];
               target_in = req_tuser[2:1];
               layer_in  = req_tdata[1:0];
               level_in  = req_tdata[5:2];
               morton_in = req_tdata[53:6];
               sv_in     = req_tdata[54];
               state_in  = ST_EVAL;
            end
         end
         ST_EVAL: begin
            m_in        = m_sel;
            mbase_in    = AW'(m_sel) * AW'(TreeBytes);
            byte_in     = is_child ? itab_pkg::BYTE_W'(morton_ff >> 3) :
                                     bit_idx[itab_pkg::IDX_W-1:3];
            pos_in      = is_child ? morton_ff[2:0] : bit_idx[2:0];
            oor_in      = !is_child && ((morton_ff >> lvl_sh) != '0);
            fill_len_in = LW'((fill_tiles + 64'd7) >> 3);
            fill_cnt_in = '0;
            fill_val_in = map_val_ff[m_sel];
            if (bad_req) begin
               if (out_free) begin
                  rsp_load     = 1'b1;
                  rsp_avail_in = 1'b0;
                  rsp_rej_in   = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (op_ff == itab_pkg::OP_QUERY) begin
               if (!is_child && ((morton_ff >> lvl_sh) != '0)) begin
                  if (out_free) begin
                     rsp_load     = 1'b1;
                     rsp_avail_in = 1'b0;
                     rsp_rej_in   = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end else if (map_const_ff[m_sel]) begin
                  if (out_free) begin
                     rsp_load     = 1'b1;
                     rsp_avail_in = map_val_ff[m_sel];
                     rsp_rej_in   = 1'b0;
                     state_in     = ST_IDLE;
                  end
               end else begin
                  state_in = ST_ACCESS;
               end
            end else begin
               if (map_const_ff[m_sel] && (map_val_ff[m_sel] == sv_ff)) begin
                  if (out_free) begin
                     rsp_load     = 1'b1;
                     rsp_avail_in = 1'b0;
                     rsp_rej_in   = 1'b0;
                     state_in     = ST_IDLE;
                  end
               end else if (map_const_ff[m_sel]) begin
                  state_in = ST_FILL;
               end else begin
                  state_in = ST_ACCESS;
               end
            end
         end
         ST_FILL: begin
            // One byte per cycle; the map turns into a bitstream when done.
            if (fill_cnt_ff == fill_len_ff) begin
               map_len_in[m_ff]   = fill_len_ff;
               map_const_in[m_ff] = 1'b0;
               state_in           = ST_ACCESS;
            end else begin
               fill_cnt_in = fill_cnt_ff + LW'(1);
            end
         end
         ST_ACCESS: begin
            if (acc_rej) begin
               if (out_free) begin
                  rsp_load     = 1'b1;
                  rsp_avail_in = 1'b0;
                  rsp_rej_in   = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               state_in = ST_MODIFY;
            end
         end
         ST_MODIFY: begin
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_avail_in = (op_ff == itab_pkg::OP_QUERY) ? rd_data_ff[pos_ff] : 1'b0;
               rsp_rej_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Sequencer state, map descriptors, configuration and response registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         octree_ff    <= 1'b0;
         levels_ff    <= 3'd3;
         count_ff     <= 3'd1;
         for (int i = 0; i < NMaps; i++) begin
            map_const_ff[i] <= 1'b1;
            map_val_ff[i]   <= (i == 0);
            map_len_ff[i]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         octree_ff    <= octree_in;
         levels_ff    <= levels_in;
         count_ff     <= count_in;
         map_const_ff <= map_const_in;
         map_len_ff   <= map_len_in;
      end
      op_ff        <= op_in;
      target_ff    <= target_in;
      layer_ff     <= layer_in;
      level_ff     <= level_in;
      morton_ff    <= morton_in;
      sv_ff        <= sv_in;
      m_ff         <= m_in;
      mbase_ff     <= mbase_in;
      byte_ff      <= byte_in;
      pos_ff       <= pos_in;
      oor_ff       <= oor_in;
      fill_len_ff  <= fill_len_in;
      fill_cnt_ff  <= fill_cnt_in;
      fill_val_ff  <= fill_val_in;
      rsp_avail_ff <= rsp_avail_in;
      rsp_rej_ff   <= rsp_rej_in;
   end

   // Map memory with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_ra];
      end
   end

   // An accepted word is always decoded in the next cycle.
   `ITAB_ASSERT_NXT(a_accept_eval, req_tvalid && req_tready, state_ff == ST_EVAL, "accepted word not decoded")
   // The memory is written only by the fill sweep or the write-back step.
   `ITAB_ASSERT_IMP(a_write_state, mem_we, (state_ff == ST_FILL) || (state_ff == ST_MODIFY), "stray map write")
   // The fill sweep never writes past the converted map length.
   `ITAB_ASSERT_IMP(a_fill_bound, mem_we && (state_ff == ST_FILL), fill_cnt_ff < fill_len_ff, "fill overrun")
   // A set never reports availability.
   `ITAB_ASSERT_NXT(a_set_no_avail, rsp_load && (op_ff == itab_pkg::OP_SET), !rsp_avail_ff, "set reported available")

endmodule
